// ===== sv/abl_pkg.sv =====
`default_nettype none

package abl_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 32;

    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 2;
    localparam int TYPE_W    = 2;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 5;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_FRAME  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;

    localparam logic [TYPE_W-1:0] FT_HELLO   = 2'd0;
    localparam logic [TYPE_W-1:0] FT_WELCOME = 2'd1;
    localparam logic [TYPE_W-1:0] FT_LINK    = 2'd2;
    localparam logic [TYPE_W-1:0] FT_BYE     = 2'd3;

    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPS        = 2'd2;

    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 6'd32;
    localparam logic [BYTE_W-1:0] VERSION_RST     = 8'd1;
    localparam logic [BYTE_W-1:0] CAPS_RST        = 8'd0;

    localparam logic [LEN_W-1:0] WELCOME_LEN = 6'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic push;
    } abl_cmd_t;

    typedef struct packed {
        logic final_item;
    } abl_sts_t;

endpackage

`default_nettype wire

// ===== sv/abl_ifs.sv =====
`default_nettype none

interface abl_in_if;
    logic                          valid;
    logic                          ready;
    logic [abl_pkg::OP_W-1:0]      operation;
    logic                          frame_valid;
    logic [abl_pkg::TYPE_W-1:0]    frame_type;
    logic                          frame_seq;
    logic                          frame_ack;
    logic [abl_pkg::LEN_W-1:0]     frame_len;
    logic [abl_pkg::IDX_W-1:0]     tx_index;
    logic [abl_pkg::BYTE_W-1:0]    tx_data;
    logic [abl_pkg::COUNT_W-1:0]   tx_count;

    modport source (
        output valid, operation, frame_valid, frame_type, frame_seq, frame_ack,
               frame_len, tx_index, tx_data, tx_count,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_valid, frame_type, frame_seq, frame_ack,
               frame_len, tx_index, tx_data, tx_count,
        output ready
    );
endinterface

interface abl_out_if;
    logic                          valid;
    logic                          ready;
    logic [abl_pkg::KIND_W-1:0]    item_kind;
    logic [abl_pkg::LEN_W-1:0]     new_payload_len;
    logic                          session_was_reset;
    logic                          session_dropped;
    logic                          tx_ready;
    logic [abl_pkg::TYPE_W-1:0]    reply_type;
    logic                          resp_seq;
    logic                          resp_ack;
    logic [abl_pkg::LEN_W-1:0]     resp_len;
    logic [abl_pkg::BYTE_W-1:0]    payload_byte;
    logic                          last;

    modport source (
        output valid, item_kind, new_payload_len, session_was_reset, session_dropped,
               tx_ready, reply_type, resp_seq, resp_ack, resp_len, payload_byte,
               last,
        input  ready
    );
    modport sink (
        input  valid, item_kind, new_payload_len, session_was_reset, session_dropped,
               tx_ready, reply_type, resp_seq, resp_ack, resp_len, payload_byte,
               last,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/abl_ctrl.sv =====
`default_nettype none

module abl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output abl_pkg::abl_cmd_t      cmd,
    input  wire abl_pkg::abl_sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd.load = in_valid && in_ready;
        cmd.exec = (state_reg == ST_EXEC);
        cmd.push = (state_reg == ST_EMIT) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.push && sts.final_item)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/abl_datapath.sv =====
`default_nettype none

module abl_datapath #(
    parameter int PAYLOAD_DEPTH = abl_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire abl_pkg::abl_cmd_t                 cmd,
    output abl_pkg::abl_sts_t                      sts,
    input  wire logic                              cfg_we,
    input  wire logic [abl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [abl_pkg::BYTE_W-1:0]        cfg_data,
    input  wire logic [abl_pkg::OP_W-1:0]          operation,
    input  wire logic                              frame_valid,
    input  wire logic [abl_pkg::TYPE_W-1:0]        frame_type,
    input  wire logic                              frame_seq,
    input  wire logic                              frame_ack,
    input  wire logic [abl_pkg::LEN_W-1:0]         frame_len,
    input  wire logic [abl_pkg::IDX_W-1:0]         tx_index,
    input  wire logic [abl_pkg::BYTE_W-1:0]        tx_data,
    input  wire logic [abl_pkg::COUNT_W-1:0]       tx_count,
    output logic [abl_pkg::KIND_W-1:0]             item_kind,
    output logic [abl_pkg::LEN_W-1:0]              new_payload_len,
    output logic                                   session_was_reset,
    output logic                                   session_dropped,
    output logic                                   tx_ready,
    output logic [abl_pkg::TYPE_W-1:0]             reply_type,
    output logic                                   resp_seq,
    output logic                                   resp_ack,
    output logic [abl_pkg::LEN_W-1:0]              resp_len,
    output logic [abl_pkg::BYTE_W-1:0]             payload_byte,
    output logic                                   last
);

    localparam int LEN_W     = abl_pkg::LEN_W;
    localparam int BYTE_W    = abl_pkg::BYTE_W;
    localparam int ADDR_W    = $clog2(PAYLOAD_DEPTH);
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [1:0] CLS_STATUS  = 2'd0;
    localparam logic [1:0] CLS_WELCOME = 2'd1;
    localparam logic [1:0] CLS_LINK    = 2'd2;

    // configuration
    logic [LEN_W-1:0]  max_payload_reg;
    logic [BYTE_W-1:0] version_reg;
    logic [BYTE_W-1:0] caps_reg;

    // latched input item
    logic [abl_pkg::OP_W-1:0]    op_reg;
    logic                        fvalid_reg;
    logic [abl_pkg::TYPE_W-1:0]  ftype_reg;
    logic                        fseq_reg;
    logic                        fack_reg;
    logic [LEN_W-1:0]            flen_reg;
    logic [abl_pkg::IDX_W-1:0]   tidx_reg;
    logic [BYTE_W-1:0]           tdata_reg;
    logic [abl_pkg::COUNT_W-1:0] tcnt_reg;

    // link state
    logic             linked_reg,  linked_next;
    logic             rx_seq_reg,  rx_seq_next;
    logic             tx_seq_reg,  tx_seq_next;
    logic             outst_reg,   outst_next;
    logic [LEN_W-1:0] tx_len_reg,  tx_len_next;

    // response context
    logic [1:0]                  cls_reg,      cls_next;
    logic [LEN_W-1:0]            dlen_reg,     dlen_next;
    logic                        srst_reg,     srst_next;
    logic                        lost_reg,     lost_next;
    logic [abl_pkg::TYPE_W-1:0]  rtype_reg,    rtype_next;
    logic                        rseq_reg,     rseq_next;
    logic                        rack_reg,     rack_next;
    logic [LEN_W-1:0]            rlen_reg,     rlen_next;
    logic [LEN_W-1:0]            last_idx_reg, last_idx_next;
    logic [LEN_W-1:0]            cnt_reg,      cnt_next;

    // tx payload store
    logic [BYTE_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [BYTE_W-1:0]    rd_mem_reg;
    logic                 rd_vld_reg;

    logic              frame_ok;
    logic              tx_rdy;
    logic              rel_outst;
    logic              rel_seq;
    logic [LEN_W-1:0]  rel_len;
    logic              new_rx_seq;
    logic [LEN_W-1:0]  new_dlen;

    // current item
    logic [abl_pkg::KIND_W-1:0] cur_kind;
    logic [BYTE_W-1:0]          cur_byte;

    assign sts.final_item = (cnt_reg == last_idx_reg);
    assign tx_rdy         = linked_reg && !outst_reg;
    assign frame_ok       = (op_reg == abl_pkg::OP_FRAME) && fvalid_reg
                            && (flen_reg <= max_payload_reg)
                            && (int'(flen_reg) <= PAYLOAD_DEPTH);

    // release on matching ack, then accept a new payload
    always_comb
    begin
        rel_outst  = outst_reg;
        rel_seq    = tx_seq_reg;
        rel_len    = tx_len_reg;
        new_rx_seq = rx_seq_reg;
        new_dlen   = '0;
        if (outst_reg && (fack_reg == tx_seq_reg))
        begin
            rel_outst = 1'b0;
            rel_len   = '0;
            rel_seq   = !tx_seq_reg;
        end
        if ((flen_reg != '0) && (fseq_reg != rx_seq_reg))
        begin
            new_rx_seq = fseq_reg;
            new_dlen   = flen_reg;
        end
    end

    always_comb
    begin
        linked_next   = linked_reg;
        rx_seq_next   = rx_seq_reg;
        tx_seq_next   = tx_seq_reg;
        outst_next    = outst_reg;
        tx_len_next   = tx_len_reg;
        cls_next      = cls_reg;
        dlen_next     = dlen_reg;
        srst_next     = srst_reg;
        lost_next     = lost_reg;
        rtype_next    = rtype_reg;
        rseq_next     = rseq_reg;
        rack_next     = rack_reg;
        rlen_next     = rlen_reg;
        last_idx_next = last_idx_reg;
        wr_en         = 1'b0;
        wr_addr       = ADDR_W'(tidx_reg);
        if (cmd.exec)
        begin
            cls_next      = CLS_STATUS;
            dlen_next     = '0;
            srst_next     = 1'b0;
            lost_next     = 1'b0;
            rtype_next    = abl_pkg::FT_HELLO;
            rseq_next     = 1'b0;
            rack_next     = 1'b0;
            rlen_next     = '0;
            last_idx_next = '0;
            if (op_reg == abl_pkg::OP_WRITE)
            begin
                wr_en = tx_rdy && (int'(tidx_reg) < PAYLOAD_DEPTH);
            end
            else if (op_reg == abl_pkg::OP_COMMIT)
            begin
                if (tx_rdy)
                begin
                    if (int'(tcnt_reg) > PAYLOAD_DEPTH)
                    begin
                        tx_len_next = LEN_W'(PAYLOAD_DEPTH);
                    end
                    else
                    begin
                        tx_len_next = LEN_W'(tcnt_reg);
                    end
                    outst_next = (tcnt_reg != '0);
                end
            end
            else if (frame_ok && (ftype_reg == abl_pkg::FT_HELLO))
            begin
                linked_next   = 1'b1;
                rx_seq_next   = 1'b1;
                tx_seq_next   = 1'b0;
                outst_next    = 1'b0;
                tx_len_next   = '0;
                cls_next      = CLS_WELCOME;
                srst_next     = 1'b1;
                rtype_next    = abl_pkg::FT_WELCOME;
                rlen_next     = abl_pkg::WELCOME_LEN;
                last_idx_next = abl_pkg::WELCOME_LEN;
            end
            else if (frame_ok && linked_reg && (ftype_reg == abl_pkg::FT_BYE))
            begin
                linked_next = 1'b0;
                rx_seq_next = 1'b1;
                tx_seq_next = 1'b0;
                outst_next  = 1'b0;
                tx_len_next = '0;
                lost_next   = 1'b1;
            end
            else if (frame_ok && linked_reg && (ftype_reg == abl_pkg::FT_LINK))
            begin
                outst_next    = rel_outst;
                tx_seq_next   = rel_seq;
                tx_len_next   = rel_len;
                rx_seq_next   = new_rx_seq;
                cls_next      = CLS_LINK;
                dlen_next     = new_dlen;
                rtype_next    = abl_pkg::FT_LINK;
                rseq_next     = rel_seq;
                rack_next     = new_rx_seq;
                rlen_next     = rel_outst ? rel_len : '0;
                last_idx_next = rel_outst ? rel_len : '0;
            end
        end
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            cnt_next = '0;
        end
        else if (cmd.push)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // keep the byte for the current item in the read register
    assign rd_addr = ADDR_W'(cnt_next - 1'b1);

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            cur_kind = (cls_reg == CLS_STATUS) ? abl_pkg::KIND_STATUS
                                               : abl_pkg::KIND_HEADER;
        end
        else
        begin
            cur_kind = abl_pkg::KIND_PAYLOAD;
        end
        cur_byte = '0;
        if (cnt_reg != '0)
        begin
            case (cls_reg)
                CLS_WELCOME:
                begin
                    if (cnt_reg == LEN_W'(1))
                    begin
                        cur_byte = version_reg;
                    end
                    else if (cnt_reg == LEN_W'(2))
                    begin
                        cur_byte = caps_reg;
                    end
                    else
                    begin
                        cur_byte = BYTE_W'(max_payload_reg);
                    end
                end
                CLS_LINK:
                begin
                    cur_byte = rd_vld_reg ? rd_mem_reg : '0;
                end
                default:
                begin
                    cur_byte = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= abl_pkg::MAX_PAYLOAD_RST;
            version_reg     <= abl_pkg::VERSION_RST;
            caps_reg        <= abl_pkg::CAPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abl_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[LEN_W-1:0];
                abl_pkg::CFG_VERSION:     version_reg     <= cfg_data;
                abl_pkg::CFG_CAPS:        caps_reg        <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linked_reg <= 1'b0;
            rx_seq_reg <= 1'b1;
            tx_seq_reg <= 1'b0;
            outst_reg  <= 1'b0;
            tx_len_reg <= '0;
            vld_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            linked_reg <= linked_next;
            rx_seq_reg <= rx_seq_next;
            tx_seq_reg <= tx_seq_next;
            outst_reg  <= outst_next;
            tx_len_reg <= tx_len_next;
            cnt_reg    <= cnt_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= tdata_reg;
        end
        rd_mem_reg <= mem[rd_addr];
        rd_vld_reg <= vld_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            fvalid_reg <= frame_valid;
            ftype_reg  <= frame_type;
            fseq_reg   <= frame_seq;
            fack_reg   <= frame_ack;
            flen_reg   <= frame_len;
            tidx_reg   <= tx_index;
            tdata_reg  <= tx_data;
            tcnt_reg   <= tx_count;
        end
        cls_reg      <= cls_next;
        dlen_reg     <= dlen_next;
        srst_reg     <= srst_next;
        lost_reg     <= lost_next;
        rtype_reg    <= rtype_next;
        rseq_reg     <= rseq_next;
        rack_reg     <= rack_next;
        rlen_reg     <= rlen_next;
        last_idx_reg <= last_idx_next;
        if (cmd.push)
        begin
            item_kind         <= cur_kind;
            new_payload_len   <= dlen_reg;
            session_was_reset <= srst_reg;
            session_dropped   <= lost_reg;
            tx_ready          <= tx_rdy;
            reply_type        <= rtype_reg;
            resp_seq          <= rseq_reg;
            resp_ack          <= rack_reg;
            resp_len          <= rlen_reg;
            payload_byte      <= cur_byte;
            last              <= sts.final_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/alternating_bit_link_slave.sv =====
`default_nettype none

// Channel     Dir  Handshake        Payload
// item_in     in   valid / ready    operation, frame header, tx byte write, tx commit
// item_out    out  valid / ready    status, response header or response payload byte
// cfg         in   cfg_we           cfg_index, cfg_data (no read-back)
//
// Each input item is latched and executed, then its result items are emitted one
// item a cycle while item_out is not stalled: 1 for status, 4 for WELCOME, 1 + tx
// length for LINK (up to 1 + PAYLOAD_DEPTH). A stalled item_out holds the emission;
// item_in is taken again after the last result item enters the output register.
// Reset is asynchronous and clears link state and store valid bits at once.

module alternating_bit_link_slave #(
    parameter int PAYLOAD_DEPTH = abl_pkg::PAYLOAD_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    abl_in_if.sink                              item_in,
    abl_out_if.source                           item_out,
    input  wire logic                           cfg_we,
    input  wire logic [abl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [abl_pkg::BYTE_W-1:0]     cfg_data
);

    abl_pkg::abl_cmd_t cmd;
    abl_pkg::abl_sts_t sts;

    abl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_ready (item_out.ready),
        .out_valid (item_out.valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    abl_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .operation         (item_in.operation),
        .frame_valid       (item_in.frame_valid),
        .frame_type        (item_in.frame_type),
        .frame_seq         (item_in.frame_seq),
        .frame_ack         (item_in.frame_ack),
        .frame_len         (item_in.frame_len),
        .tx_index          (item_in.tx_index),
        .tx_data           (item_in.tx_data),
        .tx_count          (item_in.tx_count),
        .item_kind         (item_out.item_kind),
        .new_payload_len   (item_out.new_payload_len),
        .session_was_reset (item_out.session_was_reset),
        .session_dropped   (item_out.session_dropped),
        .tx_ready          (item_out.tx_ready),
        .reply_type        (item_out.reply_type),
        .resp_seq          (item_out.resp_seq),
        .resp_ack          (item_out.resp_ack),
        .resp_len          (item_out.resp_len),
        .payload_byte      (item_out.payload_byte),
        .last              (item_out.last)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int OP_W      = abl_pkg::OP_W;
    localparam int TYPE_W    = abl_pkg::TYPE_W;
    localparam int LEN_W     = abl_pkg::LEN_W;
    localparam int IDX_W     = abl_pkg::IDX_W;
    localparam int BYTE_W    = abl_pkg::BYTE_W;
    localparam int COUNT_W   = abl_pkg::COUNT_W;
    localparam int KIND_W    = abl_pkg::KIND_W;
    localparam int CFG_IDX_W = abl_pkg::CFG_IDX_W;

    localparam int STORE_DEPTH = abl_pkg::PAYLOAD_DEPTH_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic               frame_valid;
        logic [TYPE_W-1:0]  frame_type;
        logic               frame_seq;
        logic               frame_ack;
        logic [LEN_W-1:0]   frame_len;
        logic [IDX_W-1:0]   tx_index;
        logic [BYTE_W-1:0]  tx_data;
        logic [COUNT_W-1:0] tx_count;
    } link_req_t;

    localparam int REQ_W = $bits(link_req_t);

    typedef struct packed {
        logic [KIND_W-1:0]  item_kind;
        logic [LEN_W-1:0]   new_payload_len;
        logic               session_was_reset;
        logic               session_dropped;
        logic               tx_ready;
        logic [TYPE_W-1:0]  reply_type;
        logic               resp_seq;
        logic               resp_ack;
        logic [LEN_W-1:0]   resp_len;
        logic [BYTE_W-1:0]  payload_byte;
        logic               last;
    } link_reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    abl_in_if  frame_ch ();
    abl_out_if reply_ch ();

    alternating_bit_link_slave u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (frame_ch),
        .item_out  (reply_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic              lnk;
    logic              rx_seq_seen;
    logic              tx_seq;
    logic              tx_pend;
    logic [LEN_W-1:0]  tx_len;
    logic [BYTE_W-1:0] tx_mem [STORE_DEPTH];
    logic [LEN_W-1:0]  max_len_reg;
    logic [BYTE_W-1:0] version_reg;
    logic [BYTE_W-1:0] caps_reg;

    link_reply_t owed_replies [$];
    int          mismatch_count;
    int          sender_idle_max;
    int          sink_idle_max;
    int          sink_hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic string describe(input link_reply_t r);
        string head;
        string tail;
        head = $sformatf("kind=%0d dlen=%0d srst=%0b drop=%0b rdy=%0b type=%0d seq=%0b ",
                         r.item_kind, r.new_payload_len, r.session_was_reset,
                         r.session_dropped, r.tx_ready, r.reply_type, r.resp_seq);
        tail = $sformatf("ack=%0b len=%0d byte=%02h last=%0b",
                         r.resp_ack, r.resp_len, r.payload_byte, r.last);
        return {head, tail};
    endfunction

    task automatic report(input string what, input link_reply_t want, input link_reply_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s", $realtime, what);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
        end
    endtask

    task automatic clear_session();
        rx_seq_seen = 1'b1;
        tx_seq      = 1'b0;
        tx_pend     = 1'b0;
        tx_len      = '0;
    endtask

    task automatic push_reply(input logic [KIND_W-1:0] kind, input logic [LEN_W-1:0] dlen,
                              input logic srst, input logic lost,
                              input logic [TYPE_W-1:0] rtype, input logic rseq,
                              input logic rack, input logic [LEN_W-1:0] rlen,
                              input logic [BYTE_W-1:0] data, input logic fin);
        link_reply_t r;
        r.item_kind         = kind;
        r.new_payload_len   = dlen;
        r.session_was_reset = srst;
        r.session_dropped   = lost;
        r.tx_ready          = lnk && !tx_pend;
        r.reply_type        = rtype;
        r.resp_seq          = rseq;
        r.resp_ack          = rack;
        r.resp_len          = rlen;
        r.payload_byte      = data;
        r.last              = fin;
        owed_replies.push_back(r);
    endtask

    task automatic push_status(input logic lost);
        push_reply(abl_pkg::KIND_STATUS, '0, 1'b0, lost, '0, 1'b0, 1'b0, '0, '0, 1'b1);
    endtask

    // advance the link state by one accepted item and queue the replies it owes
    task automatic step_link(input link_req_t q);
        logic [LEN_W-1:0]   dlen;
        logic [LEN_W-1:0]   rlen;
        logic [COUNT_W-1:0] cnt;
        logic [BYTE_W-1:0]  hello_bytes [3];
        int                 i;
        dlen = '0;
        if (q.operation == abl_pkg::OP_WRITE)
        begin
            if (lnk && !tx_pend && q.tx_index < STORE_DEPTH)
                tx_mem[q.tx_index] = q.tx_data;
            push_status(1'b0);
        end
        else if (q.operation == abl_pkg::OP_COMMIT)
        begin
            if (lnk && !tx_pend)
            begin
                cnt     = (q.tx_count > STORE_DEPTH) ? COUNT_W'(STORE_DEPTH) : q.tx_count;
                tx_len  = cnt[LEN_W-1:0];
                tx_pend = (cnt != 0);
            end
            push_status(1'b0);
        end
        else if (q.operation != abl_pkg::OP_FRAME || !q.frame_valid
                 || q.frame_len > max_len_reg || q.frame_len > STORE_DEPTH)
            push_status(1'b0);
        else if (q.frame_type == abl_pkg::FT_HELLO)
        begin
            clear_session();
            lnk = 1'b1;
            hello_bytes[0] = version_reg;
            hello_bytes[1] = caps_reg;
            hello_bytes[2] = {2'b00, max_len_reg};
            push_reply(abl_pkg::KIND_HEADER, '0, 1'b1, 1'b0, abl_pkg::FT_WELCOME, 1'b0, 1'b0,
                       abl_pkg::WELCOME_LEN, '0, 1'b0);
            for (i = 0; i < 3; i++)
                push_reply(abl_pkg::KIND_PAYLOAD, '0, 1'b1, 1'b0, abl_pkg::FT_WELCOME, 1'b0,
                           1'b0, abl_pkg::WELCOME_LEN, hello_bytes[i], i == 2);
        end
        else if (!lnk || q.frame_type == abl_pkg::FT_WELCOME)
            push_status(1'b0);
        else if (q.frame_type == abl_pkg::FT_BYE)
        begin
            clear_session();
            lnk = 1'b0;
            push_status(1'b1);
        end
        else
        begin
            if (tx_pend && q.frame_ack == tx_seq)
            begin
                tx_pend = 1'b0;
                tx_len  = '0;
                tx_seq  = ~tx_seq;
            end
            if (q.frame_len != 0 && q.frame_seq != rx_seq_seen)
            begin
                rx_seq_seen = q.frame_seq;
                dlen        = q.frame_len;
            end
            rlen = tx_pend ? tx_len : '0;
            push_reply(abl_pkg::KIND_HEADER, dlen, 1'b0, 1'b0, abl_pkg::FT_LINK, tx_seq,
                       rx_seq_seen, rlen, '0, rlen == 0);
            for (i = 0; i < rlen; i++)
                push_reply(abl_pkg::KIND_PAYLOAD, dlen, 1'b0, 1'b0, abl_pkg::FT_LINK, tx_seq,
                           rx_seq_seen, rlen, tx_mem[i], i + 1 == rlen);
        end
    endtask

    function automatic link_req_t frame_item(input logic [TYPE_W-1:0] ftype, input logic seq,
                                             input logic ack, input int len);
        link_req_t q;
        q             = '0;
        q.operation   = abl_pkg::OP_FRAME;
        q.frame_valid = 1'b1;
        q.frame_type  = ftype;
        q.frame_seq   = seq;
        q.frame_ack   = ack;
        q.frame_len   = LEN_W'(len);
        return q;
    endfunction

    function automatic link_req_t write_item(input int idx, input logic [BYTE_W-1:0] data);
        link_req_t q;
        q           = '0;
        q.operation = abl_pkg::OP_WRITE;
        q.tx_index  = IDX_W'(idx);
        q.tx_data   = data;
        return q;
    endfunction

    function automatic link_req_t commit_item(input int cnt);
        link_req_t q;
        q           = '0;
        q.operation = abl_pkg::OP_COMMIT;
        q.tx_count  = COUNT_W'(cnt);
        return q;
    endfunction

    // mostly well-formed traffic that follows the session, with some noise
    function automatic link_req_t draw_item();
        logic [REQ_W-1:0] raw;
        link_req_t q;
        int        pick;
        int        lim;
        raw  = REQ_W'({$urandom, $urandom});
        q    = raw;
        lim  = (max_len_reg < STORE_DEPTH) ? max_len_reg : STORE_DEPTH;
        pick = $urandom_range(0, 99);
        if (!lnk && pick < 60)
            pick = 0;
        if (pick < 6)
            q = frame_item(abl_pkg::FT_HELLO, q.frame_seq, q.frame_ack,
                           $urandom_range(0, lim));
        else if (pick < 36)
            q.operation = abl_pkg::OP_WRITE;
        else if (pick < 50)
        begin
            q.operation = abl_pkg::OP_COMMIT;
            if ($urandom_range(0, 7) != 0)
                q.tx_count = COUNT_W'($urandom_range(0, 6));
        end
        else if (pick < 86)
            q = frame_item(abl_pkg::FT_LINK,
                           ($urandom_range(0, 4) == 0) ? rx_seq_seen : ~rx_seq_seen,
                           ($urandom_range(0, 3) == 0) ? ~tx_seq : tx_seq,
                           $urandom_range(0, lim));
        else if (pick < 90)
            q = frame_item(abl_pkg::FT_BYE, q.frame_seq, q.frame_ack,
                           $urandom_range(0, lim));
        return q;
    endfunction

    task automatic send_item(input link_req_t q);
        int gap;
        gap = $urandom_range(0, sender_idle_max);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid       <= 1'b1;
        frame_ch.operation   <= q.operation;
        frame_ch.frame_valid <= q.frame_valid;
        frame_ch.frame_type  <= q.frame_type;
        frame_ch.frame_seq   <= q.frame_seq;
        frame_ch.frame_ack   <= q.frame_ack;
        frame_ch.frame_len   <= q.frame_len;
        frame_ch.tx_index    <= q.tx_index;
        frame_ch.tx_data     <= q.tx_data;
        frame_ch.tx_count    <= q.tx_count;
        do
            @(posedge clk);
        while (frame_ch.ready !== 1'b1);
        step_link(q);
    endtask

    task automatic drain();
        frame_ch.valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            abl_pkg::CFG_MAX_PAYLOAD: max_len_reg = data[LEN_W-1:0];
            abl_pkg::CFG_VERSION:     version_reg = data;
            abl_pkg::CFG_CAPS:        caps_reg    = data;
            default: ;
        endcase
    endtask

    task automatic set_registers(input int max_len, input logic [BYTE_W-1:0] version,
                                 input logic [BYTE_W-1:0] caps);
        drain();
        write_reg(abl_pkg::CFG_MAX_PAYLOAD, BYTE_W'(max_len));
        write_reg(abl_pkg::CFG_VERSION, version);
        write_reg(abl_pkg::CFG_CAPS, caps);
        cfg_we <= 1'b0;
    endtask

    task automatic test_listening();
        link_req_t q;
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b0, 4));
        send_item(frame_item(abl_pkg::FT_BYE, 1'b1, 1'b1, 0));
        send_item(write_item(0, 8'hFF));
        send_item(commit_item(5));
        q = frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 0);
        q.frame_valid = 1'b0;
        send_item(q);
        q = frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 0);
        q.operation = OP_UNUSED;
        send_item(q);
    endtask

    task automatic test_session_open();
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 33));
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b1, 1'b1, 32));
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 0));
    endtask

    task automatic test_transfer();
        send_item(write_item(0, 8'hFF));
        send_item(write_item(31, 8'hA5));
        send_item(write_item(1, 8'h00));
        send_item(commit_item(200));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b1, 5));
        send_item(write_item(2, 8'h77));
        send_item(commit_item(3));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b1, 5));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b1, 1'b0, 0));
        send_item(frame_item(abl_pkg::FT_WELCOME, 1'b1, 1'b0, 2));
        send_item(commit_item(0));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b1, 1'b1, 32));
        send_item(write_item(4, 8'h3C));
        send_item(commit_item(5));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b1, 1));
    endtask

    task automatic test_session_end();
        send_item(frame_item(abl_pkg::FT_BYE, 1'b0, 1'b0, 0));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b0, 3));
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 1));
        send_item(commit_item(7));
        send_item(frame_item(abl_pkg::FT_BYE, 1'b1, 1'b0, 2));
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 0));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b1, 0));
    endtask

    task automatic test_registers();
        set_registers(0, 8'hFF, 8'hFF);
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 1));
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 0));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b0, 0));
        set_registers(63, 8'h00, 8'h80);
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 40));
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 32));
        set_registers(1, 8'h80, 8'h01);
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b0, 2));
        send_item(frame_item(abl_pkg::FT_LINK, 1'b0, 1'b0, 1));
    endtask

    task automatic test_backpressure();
        int i;
        set_registers(32, 8'h5A, 8'hC3);
        sink_hold_off = 300;
        send_item(frame_item(abl_pkg::FT_HELLO, 1'b0, 1'b0, 0));
        for (i = 0; i < 4; i++)
            send_item(write_item(i + 8, BYTE_W'($urandom)));
        send_item(commit_item(255));
        for (i = 0; i < 5; i++)
            send_item(frame_item(abl_pkg::FT_LINK, i[0], 1'b1, 7));
    endtask

    task automatic test_random(input int max_len, input logic [BYTE_W-1:0] version,
                               input logic [BYTE_W-1:0] caps, input bit quiet, input int n);
        int i;
        set_registers(max_len, version, caps);
        sender_idle_max = quiet ? 0 : 16;
        sink_idle_max   = quiet ? 0 : 16;
        for (i = 0; i < n; i++)
            send_item(draw_item());
    endtask

    initial
    begin : reply_sink
        link_reply_t got;
        link_reply_t want;
        int          wait_left;
        wait_left = 0;
        reply_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1)
            begin
                got.item_kind         = reply_ch.item_kind;
                got.new_payload_len   = reply_ch.new_payload_len;
                got.session_was_reset = reply_ch.session_was_reset;
                got.session_dropped   = reply_ch.session_dropped;
                got.tx_ready          = reply_ch.tx_ready;
                got.reply_type        = reply_ch.reply_type;
                got.resp_seq          = reply_ch.resp_seq;
                got.resp_ack          = reply_ch.resp_ack;
                got.resp_len          = reply_ch.resp_len;
                got.payload_byte      = reply_ch.payload_byte;
                got.last              = reply_ch.last;
                if (owed_replies.size() == 0)
                    report("reply with none owed", '0, got);
                else
                begin
                    want = owed_replies.pop_front();
                    if (got.item_kind !== want.item_kind
                        || got.new_payload_len !== want.new_payload_len
                        || got.session_was_reset !== want.session_was_reset
                        || got.session_dropped !== want.session_dropped
                        || got.tx_ready !== want.tx_ready
                        || got.reply_type !== want.reply_type
                        || got.resp_seq !== want.resp_seq
                        || got.resp_ack !== want.resp_ack
                        || got.resp_len !== want.resp_len
                        || got.payload_byte !== want.payload_byte
                        || got.last !== want.last)
                        report("reply mismatch", want, got);
                end
                wait_left = $urandom_range(0, sink_idle_max);
            end
            if (sink_hold_off > 0)
            begin
                sink_hold_off--;
                reply_ch.ready <= 1'b0;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                reply_ch.ready <= 1'b0;
            end
            else
                reply_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        mismatch_count  = 0;
        sender_idle_max = 16;
        sink_idle_max   = 16;
        sink_hold_off   = 0;
        lnk             = 1'b0;
        clear_session();
        for (i = 0; i < STORE_DEPTH; i++)
            tx_mem[i] = '0;
        max_len_reg = abl_pkg::MAX_PAYLOAD_RST;
        version_reg = abl_pkg::VERSION_RST;
        caps_reg    = abl_pkg::CAPS_RST;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        frame_ch.valid       <= 1'b0;
        frame_ch.operation   <= '0;
        frame_ch.frame_valid <= 1'b0;
        frame_ch.frame_type  <= '0;
        frame_ch.frame_seq   <= 1'b0;
        frame_ch.frame_ack   <= 1'b0;
        frame_ch.frame_len   <= '0;
        frame_ch.tx_index    <= '0;
        frame_ch.tx_data     <= '0;
        frame_ch.tx_count    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_listening();
        test_session_open();
        test_transfer();
        test_session_end();
        test_registers();
        test_backpressure();
        test_random(32, 8'h01, 8'h00, 1'b0, 20);
        test_random(63, 8'hFF, 8'h7E, 1'b1, 20);
        test_random(1, 8'h81, 8'h42, 1'b0, 20);
        test_random(20, BYTE_W'($urandom), BYTE_W'($urandom), 1'b0, 21);

        drain();
        repeat (40) @(posedge clk);
        if (owed_replies.size() != 0)
        begin
            mismatch_count += owed_replies.size();
            $display("%0d replies never arrived", owed_replies.size());
        end
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
